FILE: design/direct_mapped_writeback_cache_defines.svh
// Assertion macros used by the cache datapath.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DMWC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define DMWC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: design/dmwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmwc_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W      = 18;
  localparam int unsigned WORD_W      = ADDR_W - 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COST_W      = 10;
  localparam int unsigned ACC_COST_W  = 12;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 80;

  // Default geometry; all three must be powers of two.
  localparam int unsigned DEF_LINE_COUNT      = 256;
  localparam int unsigned DEF_WORDS_PER_BLOCK = 16;
  localparam int unsigned DEF_MEMORY_WORDS    = 65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_READ_COST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_WRITE_COST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_READ_COST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_WRITE_COST = 2'd3;

  localparam logic [COST_W-1:0] RST_CACHE_READ_COST   = 10'd1;
  localparam logic [COST_W-1:0] RST_CACHE_WRITE_COST  = 10'd1;
  localparam logic [COST_W-1:0] RST_MEMORY_READ_COST  = 10'd100;
  localparam logic [COST_W-1:0] RST_MEMORY_WRITE_COST = 10'd50;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic lookup;
    logic wb_step;
    logic fill_step;
    logic tag_fill;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic victim_dirty;
    logic cnt_last;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: design/dmwc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dmwc_pkg::status_t status_i,
  output dmwc_pkg::cmd_t        cmd_o
);
  import dmwc_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_LOOKUP   = 3'd2;
  localparam logic [2:0] ST_WB       = 3'd3;
  localparam logic [2:0] ST_FILL     = 3'd4;
  localparam logic [2:0] ST_FILL_END = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (status_i.hit) begin
          // A hit with a free output slot finishes right here.
          if (status_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (status_i.victim_dirty) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_WB: begin
        cmd_o.wb_step = 1'b1;
        if (status_i.cnt_last) state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.cnt_last) state_d = ST_FILL_END;
      end
      ST_FILL_END: begin
        cmd_o.tag_fill = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/dmwc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "direct_mapped_writeback_cache_defines.svh"

module dmwc_datapath #(
  parameter int unsigned LINE_COUNT      = dmwc_pkg::DEF_LINE_COUNT,
  parameter int unsigned WORDS_PER_BLOCK = dmwc_pkg::DEF_WORDS_PER_BLOCK,
  parameter int unsigned MEMORY_WORDS    = dmwc_pkg::DEF_MEMORY_WORDS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dmwc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dmwc_pkg::COST_W-1:0]   cfg_data_i,
  input  wire logic                          in_op_i,
  input  wire logic [dmwc_pkg::ADDR_W-1:0]   in_address_i,
  input  wire logic [dmwc_pkg::DATA_W-1:0]   in_write_data_i,
  input  wire dmwc_pkg::cmd_t                cmd_i,
  output dmwc_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dmwc_pkg::DATA_W-1:0]        out_read_data_o,
  output logic                               out_hit_o,
  output logic                               out_wrote_back_o,
  output logic [dmwc_pkg::ACC_COST_W-1:0]    out_access_cost_o,
  output logic [dmwc_pkg::TIME_W-1:0]        out_total_time_o
);
  import dmwc_pkg::*;

  localparam int unsigned OFF_W    = $clog2(WORDS_PER_BLOCK);
  localparam int unsigned IDX_W    = $clog2(LINE_COUNT);
  localparam int unsigned TAG_SH   = OFF_W + IDX_W;
  localparam int unsigned TAG_W    = (WORD_W > TAG_SH) ? WORD_W - TAG_SH : 1;
  localparam int unsigned ENTRY_W  = TAG_W + 2;
  localparam int unsigned CACHE_AW = IDX_W + OFF_W;
  localparam int unsigned MEM_AW   = $clog2(MEMORY_WORDS);

  // Tag entry layout: valid, dirty, tag from the top bit down.
  localparam int unsigned VALID_B = TAG_W + 1;
  localparam int unsigned DIRTY_B = TAG_W;

  logic [ENTRY_W-1:0] tag_mem   [LINE_COUNT];
  logic [DATA_W-1:0]  cache_mem [LINE_COUNT * WORDS_PER_BLOCK];
  logic [DATA_W-1:0]  back_mem  [MEMORY_WORDS];

  logic [COST_W-1:0] crc_q, cwc_q, mrc_q, mwc_q;

  logic              op_q;
  logic [WORD_W-1:0] word_q;
  logic [DATA_W-1:0] wdata_q;
  logic [DATA_W-1:0] rdata_q;
  logic              hit_q, wb_q;

  logic [ENTRY_W-1:0] tag_rd_q;
  logic [DATA_W-1:0]  cache_rd_q;
  logic [DATA_W-1:0]  back_rd_q;

  logic [OFF_W-1:0] cnt_q, pend_cnt_q;
  logic [IDX_W-1:0] clr_q;
  logic             wb_pend_q, fill_pend_q;

  logic [TIME_W-1:0] total_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic              out_hit_q, out_wb_q;
  logic [ACC_COST_W-1:0] out_cost_q;
  logic [TIME_W-1:0] out_total_q;

  logic [WORD_W-1:0] in_word;
  logic [IDX_W-1:0]  in_idx;
  logic [OFF_W-1:0]  in_off;
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  off_q;
  logic [TAG_W-1:0]  tag_cur;
  logic              hit;
  logic              cnt_last;

  assign in_word = in_address_i[ADDR_W-1:2];
  assign in_idx  = IDX_W'(in_word >> OFF_W);
  assign in_off  = in_word[OFF_W-1:0];
  assign idx_q   = IDX_W'(word_q >> OFF_W);
  assign off_q   = word_q[OFF_W-1:0];
  assign tag_cur = TAG_W'(word_q >> TAG_SH);

  assign hit      = tag_rd_q[VALID_B] && (tag_rd_q[TAG_W-1:0] == tag_cur);
  assign cnt_last = (cnt_q == OFF_W'(WORDS_PER_BLOCK - 1));

  assign status_o.hit          = hit;
  assign status_o.victim_dirty = tag_rd_q[VALID_B] & tag_rd_q[DIRTY_B] & ~hit;
  assign status_o.cnt_last     = cnt_last;
  assign status_o.clr_last     = (clr_q == IDX_W'(LINE_COUNT - 1));
  assign status_o.out_free     = ~out_valid_q | out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= RST_CACHE_READ_COST;
      cwc_q <= RST_CACHE_WRITE_COST;
      mrc_q <= RST_MEMORY_READ_COST;
      mwc_q <= RST_MEMORY_WRITE_COST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CACHE_READ_COST:   crc_q <= cfg_data_i;
        REG_CACHE_WRITE_COST:  cwc_q <= cfg_data_i;
        REG_MEMORY_READ_COST:  mrc_q <= cfg_data_i;
        REG_MEMORY_WRITE_COST: mwc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tag store: cleared line by line after reset.
  logic               tag_we;
  logic [IDX_W-1:0]   tag_waddr;
  logic [ENTRY_W-1:0] tag_wdata;

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = idx_q;
    tag_wdata = {1'b1, op_q, tag_cur};
    if (cmd_i.clear_step) begin
      tag_we    = 1'b1;
      tag_waddr = clr_q;
      tag_wdata = '0;
    end else if (cmd_i.lookup && hit && op_q) begin
      tag_we = 1'b1;
    end else if (cmd_i.tag_fill) begin
      tag_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (cmd_i.accept) tag_rd_q <= tag_mem[in_idx];
  end

  // Cache word store. Fill words merge the pending write at its offset.
  logic                cache_we;
  logic [CACHE_AW-1:0] cache_waddr;
  logic [DATA_W-1:0]   cache_wdata;
  logic [CACHE_AW-1:0] cache_raddr;

  always_comb begin
    cache_we    = (cmd_i.lookup & hit & op_q) | fill_pend_q;
    cache_waddr = fill_pend_q ? {idx_q, pend_cnt_q} : {idx_q, off_q};
    if (fill_pend_q && !(op_q && (pend_cnt_q == off_q))) begin
      cache_wdata = back_rd_q;
    end else begin
      cache_wdata = wdata_q;
    end
    cache_raddr = cmd_i.accept ? {in_idx, in_off} : {idx_q, cnt_q};
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    if (cmd_i.accept || cmd_i.wb_step) cache_rd_q <= cache_mem[cache_raddr];
  end

  // Backing memory: victim words go out in the cycle after their cache read.
  logic [WORD_W-1:0] victim_word;
  logic [WORD_W-1:0] fill_word;

  assign victim_word = WORD_W'({tag_rd_q[TAG_W-1:0], idx_q, pend_cnt_q});
  assign fill_word   = {word_q[WORD_W-1:OFF_W], cnt_q};

  always_ff @(posedge clk_i) begin
    if (wb_pend_q) back_mem[MEM_AW'(victim_word)] <= cache_rd_q;
    if (cmd_i.fill_step) back_rd_q <= back_mem[MEM_AW'(fill_word)];
  end

  // Walk counters and pending-write flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_cnt_q  <= '0;
      clr_q       <= '0;
      wb_pend_q   <= 1'b0;
      fill_pend_q <= 1'b0;
    end else begin
      wb_pend_q   <= cmd_i.wb_step;
      fill_pend_q <= cmd_i.fill_step;
      if (cmd_i.wb_step || cmd_i.fill_step) begin
        pend_cnt_q <= cnt_q;
        cnt_q      <= cnt_last ? '0 : cnt_q + OFF_W'(1);
      end
      if (cmd_i.clear_step) clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= in_op_i;
      word_q  <= in_word;
      wdata_q <= in_write_data_i;
    end
    if (cmd_i.lookup) begin
      hit_q   <= hit;
      wb_q    <= status_o.victim_dirty;
      rdata_q <= cache_rd_q;
    end else if (fill_pend_q && (op_q == OP_READ) && (pend_cnt_q == off_q)) begin
      rdata_q <= back_rd_q;
    end
  end

  // Result selection and cost.
  logic [ACC_COST_W-1:0] op_cost;
  logic [ACC_COST_W-1:0] miss_cost;
  logic [ACC_COST_W-1:0] wb_cost;
  logic [ACC_COST_W-1:0] cost_sel;
  logic [DATA_W-1:0]     rdata_sel;
  logic [TIME_W-1:0]     total_d;

  always_comb begin
    op_cost   = ACC_COST_W'(op_q ? cwc_q : crc_q);
    miss_cost = hit_q ? '0 : ACC_COST_W'(mrc_q);
    wb_cost   = wb_q ? ACC_COST_W'(mwc_q) : '0;
    cost_sel  = cmd_i.lookup ? op_cost : op_cost + miss_cost + wb_cost;
    rdata_sel = cmd_i.lookup ? cache_rd_q : rdata_q;
    total_d   = total_q + TIME_W'(cost_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      total_q     <= total_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rdata_q <= (op_q == OP_WRITE) ? '0 : rdata_sel;
      out_hit_q   <= cmd_i.lookup ? 1'b1 : hit_q;
      out_wb_q    <= cmd_i.lookup ? 1'b0 : wb_q;
      out_cost_q  <= cost_sel;
      out_total_q <= total_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_data_o   = out_rdata_q;
  assign out_hit_o         = out_hit_q;
  assign out_wrote_back_o  = out_wb_q;
  assign out_access_cost_o = out_cost_q;
  assign out_total_time_o  = out_total_q;

  `DMWC_ASSERT(a_load_needs_slot, cmd_i.load_out |-> (!out_valid_q || out_ready_i), "result loaded over a waiting result")
  `DMWC_ASSERT_NEVER(a_wb_fill_overlap, wb_pend_q && fill_pend_q, "write-back and fill writes overlap")
  `DMWC_ASSERT(a_fill_drained, cmd_i.tag_fill |-> (fill_pend_q && (cnt_q == '0)), "tag written before fill ended")
  `DMWC_ASSERT_NEVER(a_accept_busy, cmd_i.accept && (wb_pend_q || fill_pend_q), "item accepted during a block walk")

endmodule

`default_nettype wire

FILE: design/direct_mapped_writeback_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Contents
// s_axis   in         tuser: op; tdata: address [17:0], write_data [49:18]
// m_axis   out        tdata: read_data, hit, wrote_back, access_cost, total_time
// cfg      in         cfg_we_i, cfg_idx_i (register 0..3), cfg_data_i (10-bit cost)
//
// After reset the tag store is cleared one line per cycle, all LINE_COUNT lines,
// before the first item is taken; configuration writes are taken at any time.
// A hit passes through accept and tag lookup. A clean miss adds the one-word-per-cycle
// fill from backing memory, the tag write and a finish step; a dirty miss adds the
// write-back walk before the fill. One item is in work at a time; the next item is
// accepted while a finished result waits in the output register.

module direct_mapped_writeback_cache #(
  parameter int unsigned LINE_COUNT      = dmwc_pkg::DEF_LINE_COUNT,
  parameter int unsigned WORDS_PER_BLOCK = dmwc_pkg::DEF_WORDS_PER_BLOCK,
  parameter int unsigned MEMORY_WORDS    = dmwc_pkg::DEF_MEMORY_WORDS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dmwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dmwc_pkg::COST_W-1:0]     cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // address [17:0], write_data [49:18], zero [55:50]
  input  wire logic [dmwc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // op [0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_data [31:0], hit [32], wrote_back [33], access_cost [45:34],
  // total_time [77:46], zero [79:78]
  output logic [dmwc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dmwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [DATA_W-1:0]     rd_data;
  logic                  rd_hit;
  logic                  rd_wb;
  logic [ACC_COST_W-1:0] rd_cost;
  logic [TIME_W-1:0]     rd_total;

  dmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmwc_datapath #(
    .LINE_COUNT      (LINE_COUNT),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
    .MEMORY_WORDS    (MEMORY_WORDS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_op_i           (s_axis_tuser),
    .in_address_i      (s_axis_tdata[ADDR_W-1:0]),
    .in_write_data_i   (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_read_data_o   (rd_data),
    .out_hit_o         (rd_hit),
    .out_wrote_back_o  (rd_wb),
    .out_access_cost_o (rd_cost),
    .out_total_time_o  (rd_total)
  );

  localparam int unsigned OUT_USED_W = DATA_W + 2 + ACC_COST_W + TIME_W;

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                         rd_total, rd_cost, rd_wb, rd_hit, rd_data};

endmodule

`default_nettype wire
